// ===== src/frt_pkg.sv =====
// ----------------------------------------------------------------------------
// frt_pkg
// Shared constants, codes and types of the fragment reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package frt_pkg;

  localparam int SLOTS      = 8;
  localparam int MAX_PIECES = 64;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PIECE_W    = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int CNT_W      = $clog2(MAX_PIECES + 1);
  localparam int RANGE_AW   = SLOT_W + PIECE_W;
  localparam int RANGE_D    = SLOTS << PIECE_W;
  localparam int QUEUE_D    = 2;
  localparam int RESULT_LIMIT = 8;

  typedef enum logic [2:0] {
    ST_ACCEPTED      = 3'd0,
    ST_COMPLETED     = 3'd1,
    ST_INVALID       = 3'd2,
    ST_DUPLICATE     = 3'd3,
    ST_EXPIRED       = 3'd4,
    ST_EVICTED       = 3'd5,
    ST_NONE_EXPIRED  = 3'd6
  } status_t;

  typedef enum logic {
    CMD_FRAGMENT = 1'b0,
    CMD_SWEEP    = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    REG_MAGIC       = 3'd0,
    REG_VERSION     = 3'd1,
    REG_HEADER_SIZE = 3'd2,
    REG_MAX_BYTES   = 3'd3,
    REG_MAX_PENDING = 3'd4,
    REG_TIMEOUT     = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [15:0] expected_version;
    logic [15:0] header_size;
    logic [23:0] max_frame_bytes;
    logic [2:0]  max_pending_frames;
    logic [31:0] frame_timeout;
  } cfg_t;

  // Classified item passed from the front to the back
  typedef struct packed {
    logic               sweep;
    logic               ok;
    logic [31:0]        now_time;
    logic [63:0]        frame_id;
    logic [63:0]        frame_stamp;
    logic [23:0]        frame_size;
    logic [23:0]        byte_offset;
    logic [23:0]        payload;
    logic [PIECE_W-1:0] piece_index;
    logic [15:0]        piece_count;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [31:0] write_offset;
    logic [63:0] frame_id;
    logic [63:0] stamp;
    logic [23:0] frame_size;
    logic [15:0] piece_count;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== src/frt_if.sv =====
// ----------------------------------------------------------------------------
// frt_if
// Channel interfaces: fragment input, result output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface frt_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] now_time;
  logic [15:0] datagram_length;
  logic [47:0] magic_and_version;
  logic [15:0] header_length;
  logic [63:0] frame_id;
  logic [63:0] frame_stamp;
  logic [31:0] frame_size;
  logic [31:0] byte_offset;
  logic [15:0] piece_index;
  logic [15:0] piece_count;
  logic [31:0] payload_length;
  modport source (output valid, command, now_time, datagram_length, magic_and_version,
                  header_length, frame_id, frame_stamp, frame_size, byte_offset,
                  piece_index, piece_count, payload_length, input ready);
  modport sink   (input valid, command, now_time, datagram_length, magic_and_version,
                  header_length, frame_id, frame_stamp, frame_size, byte_offset,
                  piece_index, piece_count, payload_length, output ready);
endinterface

interface frt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  slot;
  logic [31:0] write_offset;
  logic [63:0] out_frame_id;
  logic [63:0] out_stamp;
  logic [23:0] out_frame_size;
  logic [15:0] out_piece_count;
  logic        last;
  modport source (output valid, status, slot, write_offset, out_frame_id, out_stamp,
                  out_frame_size, out_piece_count, last, input ready);
  modport sink   (input valid, status, slot, write_offset, out_frame_id, out_stamp,
                  out_frame_size, out_piece_count, last, output ready);
endinterface

interface frt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/frt_ram.sv =====
// ----------------------------------------------------------------------------
// frt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/frt_front.sv =====
// ----------------------------------------------------------------------------
// frt_front
// Accepts input items and checks the header fields against the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_front (
  frt_in_if.sink              frag,
  input  wire frt_pkg::cfg_t  cfg,
  input  wire logic           q_full,
  output      logic           q_push,
  output      frt_pkg::item_t q_item
);

  logic [32:0] body_len;
  logic [31:0] room;
  logic        ok;

  assign body_len = {17'd0, frag.datagram_length} - {17'd0, frag.header_length};
  assign room     = frag.frame_size - frag.byte_offset;

  always_comb begin
    ok = (frag.magic_and_version[47:16] == cfg.expected_magic)
      && (frag.magic_and_version[15:0] == cfg.expected_version)
      && (frag.header_length == cfg.header_size)
      && (frag.datagram_length >= cfg.header_size)
      && (frag.frame_size != 32'd0)
      && (frag.frame_size <= {8'd0, cfg.max_frame_bytes})
      && (frag.piece_count != 16'd0)
      && (frag.piece_count <= 16'(frt_pkg::MAX_PIECES))
      && (frag.piece_index < frag.piece_count)
      && (frag.payload_length != 32'd0)
      && ({1'b0, frag.payload_length} == body_len)
      && (frag.byte_offset <= frag.frame_size)
      && (frag.payload_length <= room);
  end

  assign frag.ready = !q_full;
  assign q_push     = frag.valid && !q_full;

  always_comb begin
    q_item.sweep       = (frag.command == frt_pkg::CMD_SWEEP);
    q_item.ok          = ok;
    q_item.now_time    = frag.now_time;
    q_item.frame_id    = frag.frame_id;
    q_item.frame_stamp = frag.frame_stamp;
    q_item.frame_size  = frag.frame_size[23:0];
    q_item.byte_offset = frag.byte_offset[23:0];
    q_item.payload     = frag.payload_length[23:0];
    q_item.piece_index = frag.piece_index[frt_pkg::PIECE_W-1:0];
    q_item.piece_count = frag.piece_count;
  end

endmodule

`default_nettype wire

// ===== src/frt_queue.sv =====
// ----------------------------------------------------------------------------
// frt_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire frt_pkg::item_t push_item,
  output      logic           full,
  input  wire logic           pop,
  output      logic           not_empty,
  output      frt_pkg::item_t head
);

  localparam int PW = (frt_pkg::QUEUE_D > 1) ? $clog2(frt_pkg::QUEUE_D) : 1;

  frt_pkg::item_t       entry [frt_pkg::QUEUE_D];
  logic [PW-1:0]        wp;
  logic [PW-1:0]        rp;
  logic [$clog2(frt_pkg::QUEUE_D+1)-1:0] fill;

  assign full      = (fill == ($clog2(frt_pkg::QUEUE_D+1))'(frt_pkg::QUEUE_D));
  assign not_empty = (fill != '0);
  assign head      = entry[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= push_item;
    end
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(frt_pkg::QUEUE_D - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(frt_pkg::QUEUE_D - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/frt_back.sv =====
// ----------------------------------------------------------------------------
// frt_back
// Slot table sequencer: lookup, allocation, overlap walk, eviction, sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire frt_pkg::cfg_t  cfg,
  input  wire logic           q_valid,
  input  wire frt_pkg::item_t q_item,
  output      logic           q_pop,
  frt_out_if.source           result
);

  localparam int SW = frt_pkg::SLOT_W;
  localparam int PW = frt_pkg::PIECE_W;
  localparam int CW = frt_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_MATCH, S_ALLOC, S_TOUCH, S_SEEN, S_WALK, S_DECIDE,
    S_ENF, S_OLD, S_EVEMIT, S_SWEEP, S_SWNEXT, S_SWEMIT, S_EMIT
  } state_t;

  state_t state;
  state_t ret;

  frt_pkg::item_t   it;
  frt_pkg::result_t res;
  frt_pkg::result_t out_q;
  logic             out_valid;

  logic [frt_pkg::SLOTS-1:0] slot_valid;
  logic [63:0]   slot_id          [frt_pkg::SLOTS];
  logic [63:0]   slot_stamp       [frt_pkg::SLOTS];
  logic [23:0]   slot_size        [frt_pkg::SLOTS];
  logic [15:0]   slot_piece_total [frt_pkg::SLOTS];
  logic [CW-1:0] slot_pieces_got  [frt_pkg::SLOTS];
  logic [23:0]   slot_bytes_got   [frt_pkg::SLOTS];
  logic [31:0]   slot_touched     [frt_pkg::SLOTS];

  logic [SW-1:0] cur;
  logic [SW-1:0] w;
  logic [SW-1:0] best;
  logic [31:0]   best_age;
  logic          found;
  logic          ev_alloc;
  logic [SW:0]   evn;
  logic [CW-1:0] k;
  logic [CW-1:0] got;
  logic          pend;
  logic          bad;
  logic [frt_pkg::SLOTS-1:0] mask;

  // piece-seen rows and recorded byte ranges
  logic                          seen_we;
  logic [frt_pkg::MAX_PIECES-1:0] seen_wdata;
  logic [frt_pkg::MAX_PIECES-1:0] seen_rdata;
  logic                          rng_we;
  logic [47:0]                   rng_wdata;
  logic [47:0]                   rng_rdata;
  logic [frt_pkg::RANGE_AW-1:0]  rng_waddr;
  logic [frt_pkg::RANGE_AW-1:0]  rng_raddr;

  frt_ram #(.WIDTH(frt_pkg::MAX_PIECES), .DEPTH(frt_pkg::SLOTS)) u_seen (
    .clk(clk), .we(seen_we), .waddr(cur), .wdata(seen_wdata),
    .raddr(cur), .rdata(seen_rdata)
  );

  frt_ram #(.WIDTH(48), .DEPTH(frt_pkg::RANGE_D)) u_range (
    .clk(clk), .we(rng_we), .waddr(rng_waddr), .wdata(rng_wdata),
    .raddr(rng_raddr), .rdata(rng_rdata)
  );

  logic [23:0] fend;
  logic        issue;
  logic        hit;
  logic [SW-1:0] hit_idx;
  logic        free;
  logic [SW-1:0] free_idx;
  logic [frt_pkg::SLOTS-1:0] expired;
  logic [SW-1:0] low_idx;
  logic [frt_pkg::SLOTS-1:0] mask_rest;
  logic [31:0] age_w;
  logic        cand;
  logic [23:0] room;
  logic        over;
  logic        complete;
  logic [7:0]  live;
  logic [7:0]  lim;
  logic [7:0]  need;

  assign fend      = it.byte_offset + it.payload;
  assign issue     = (state == S_WALK) && (k < got);
  assign rng_raddr = {cur, k[PW-1:0]};
  assign rng_waddr = {cur, got[PW-1:0]};
  assign rng_wdata = {it.byte_offset, fend};
  assign age_w     = it.now_time - slot_touched[w];
  assign cand      = slot_valid[w] && (!found || (age_w > best_age));
  assign room      = (slot_bytes_got[cur] > slot_size[cur]) ? 24'd0
                   : slot_size[cur] - slot_bytes_got[cur];
  assign over      = bad || (it.payload > room);
  assign complete  = (16'(got + 1'b1) == slot_piece_total[cur])
                  && ((slot_bytes_got[cur] + it.payload) == slot_size[cur]);
  assign live      = 8'($countones(slot_valid));
  assign lim       = (cfg.max_pending_frames == 3'd0) ? 8'd1 : {5'd0, cfg.max_pending_frames};
  assign need      = (live > lim) ? live - lim : 8'd0;
  assign q_pop     = (state == S_IDLE) && q_valid;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free = 1'b0;
    free_idx = '0;
    low_idx = '0;
    for (int i = frt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && (slot_id[i] == it.frame_id)) begin
        hit = 1'b1;
        hit_idx = SW'(i);
      end
      if (!slot_valid[i]) begin
        free = 1'b1;
        free_idx = SW'(i);
      end
      if (mask[i]) begin
        low_idx = SW'(i);
      end
      expired[i] = slot_valid[i] && ((it.now_time - slot_touched[i]) > cfg.frame_timeout);
    end
    mask_rest = mask;
    mask_rest[low_idx] = 1'b0;
  end

  always_comb begin
    seen_we    = 1'b0;
    seen_wdata = seen_rdata;
    rng_we     = 1'b0;
    if (state == S_ALLOC) begin
      seen_we    = 1'b1;
      seen_wdata = '0;
    end else if ((state == S_DECIDE) && !over) begin
      seen_we    = 1'b1;
      seen_wdata = seen_rdata | ((frt_pkg::MAX_PIECES)'(1) << it.piece_index);
      rng_we     = (got < CW'(frt_pkg::MAX_PIECES));
    end
  end

  function automatic frt_pkg::result_t slot_res(frt_pkg::status_t st, logic [31:0] wo,
                                                logic lst);
    frt_pkg::result_t r;
    r.status       = st;
    r.slot         = 3'(cur);
    r.write_offset = wo;
    r.frame_id     = slot_id[cur];
    r.stamp        = slot_stamp[cur];
    r.frame_size   = slot_size[cur];
    r.piece_count  = slot_piece_total[cur];
    r.last         = lst;
    return r;
  endfunction

  function automatic frt_pkg::result_t rej_res(frt_pkg::status_t st, logic [SW-1:0] sl,
                                               logic [63:0] fid);
    frt_pkg::result_t r;
    r = '0;
    r.status   = st;
    r.slot     = 3'(sl);
    r.frame_id = fid;
    r.last     = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      out_valid  <= 1'b0;
      slot_valid <= '0;
      pend       <= 1'b0;
    end else begin
      if (out_valid && result.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      pend <= issue;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            it <= q_item;
            if (q_item.sweep) begin
              state <= S_SWEEP;
            end else if (q_item.ok) begin
              state <= S_LOOKUP;
            end else begin
              res   <= rej_res(frt_pkg::ST_INVALID, '0, q_item.frame_id);
              ret   <= S_IDLE;
              state <= S_EMIT;
            end
          end
        end
        S_LOOKUP: begin
          if (hit) begin
            cur   <= hit_idx;
            state <= S_MATCH;
          end else if (free) begin
            cur   <= free_idx;
            state <= S_ALLOC;
          end else begin
            w        <= '0;
            found    <= 1'b0;
            ev_alloc <= 1'b1;
            state    <= S_OLD;
          end
        end
        S_MATCH: begin
          if ((slot_stamp[cur] != it.frame_stamp) || (slot_size[cur] != it.frame_size)
              || (slot_piece_total[cur] != it.piece_count)) begin
            res   <= rej_res(frt_pkg::ST_INVALID, cur, it.frame_id);
            ret   <= S_IDLE;
            state <= S_EMIT;
          end else begin
            state <= S_TOUCH;
          end
        end
        S_ALLOC: begin
          slot_valid[cur]       <= 1'b1;
          slot_id[cur]          <= it.frame_id;
          slot_stamp[cur]       <= it.frame_stamp;
          slot_size[cur]        <= it.frame_size;
          slot_piece_total[cur] <= it.piece_count;
          slot_pieces_got[cur]  <= '0;
          slot_bytes_got[cur]   <= '0;
          state                 <= S_TOUCH;
        end
        S_TOUCH: begin
          slot_touched[cur] <= it.now_time;
          state             <= S_SEEN;
        end
        S_SEEN: begin
          if (seen_rdata[it.piece_index]) begin
            res   <= rej_res(frt_pkg::ST_DUPLICATE, cur, it.frame_id);
            ret   <= S_IDLE;
            state <= S_EMIT;
          end else begin
            k     <= '0;
            bad   <= 1'b0;
            got   <= slot_pieces_got[cur];
            state <= S_WALK;
          end
        end
        S_WALK: begin
          // one range read issued per cycle, compared in the cycle after
          if (issue) begin
            k <= k + 1'b1;
          end
          if (pend && (it.byte_offset < rng_rdata[23:0]) && (fend > rng_rdata[47:24])) begin
            bad <= 1'b1;
          end
          if (!issue && !pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_EMIT;
          if (over) begin
            res <= rej_res(frt_pkg::ST_INVALID, cur, it.frame_id);
            ret <= S_IDLE;
          end else begin
            slot_pieces_got[cur] <= got + 1'b1;
            slot_bytes_got[cur]  <= slot_bytes_got[cur] + it.payload;
            if (complete) begin
              res             <= slot_res(frt_pkg::ST_COMPLETED, {8'd0, it.byte_offset}, 1'b1);
              slot_valid[cur] <= 1'b0;
              ret             <= S_IDLE;
            end else begin
              res <= slot_res(frt_pkg::ST_ACCEPTED, {8'd0, it.byte_offset}, need == 8'd0);
              evn <= (SW+1)'(need);
              ret <= (need != 8'd0) ? S_ENF : S_IDLE;
            end
          end
        end
        S_ENF: begin
          w        <= '0;
          found    <= 1'b0;
          ev_alloc <= 1'b0;
          state    <= S_OLD;
        end
        S_OLD: begin
          // walk the slots for the largest idle age, lowest index on ties
          if (cand) begin
            best     <= w;
            best_age <= age_w;
            found    <= 1'b1;
          end
          if (w == SW'(frt_pkg::SLOTS - 1)) begin
            cur   <= cand ? w : best;
            state <= S_EVEMIT;
          end else begin
            w <= w + 1'b1;
          end
        end
        S_EVEMIT: begin
          slot_valid[cur] <= 1'b0;
          state           <= S_EMIT;
          if (ev_alloc) begin
            res <= slot_res(frt_pkg::ST_EVICTED, 32'd0, 1'b0);
            ret <= S_ALLOC;
          end else begin
            res <= slot_res(frt_pkg::ST_EVICTED, 32'd0, evn == (SW+1)'(1));
            evn <= evn - 1'b1;
            ret <= (evn == (SW+1)'(1)) ? S_IDLE : S_ENF;
          end
        end
        S_SWEEP: begin
          mask <= expired;
          if (expired == '0) begin
            res   <= rej_res(frt_pkg::ST_NONE_EXPIRED, '0, 64'd0);
            ret   <= S_IDLE;
            state <= S_EMIT;
          end else begin
            state <= S_SWNEXT;
          end
        end
        S_SWNEXT: begin
          cur   <= low_idx;
          mask  <= mask_rest;
          state <= S_SWEMIT;
        end
        S_SWEMIT: begin
          res             <= slot_res(frt_pkg::ST_EXPIRED, 32'd0, mask == '0);
          slot_valid[cur] <= 1'b0;
          ret             <= (mask == '0) ? S_IDLE : S_SWNEXT;
          state           <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid || result.ready) begin
            out_q     <= res;
            out_valid <= 1'b1;
            state     <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid           = out_valid;
  assign result.status          = out_q.status;
  assign result.slot            = out_q.slot;
  assign result.write_offset    = out_q.write_offset;
  assign result.out_frame_id    = out_q.frame_id;
  assign result.out_stamp       = out_q.stamp;
  assign result.out_frame_size  = out_q.frame_size;
  assign result.out_piece_count = out_q.piece_count;
  assign result.last            = out_q.last;

endmodule

`default_nettype wire

// ===== src/fragment_reassembly_tracker.sv =====
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// Tracks reassembly of fragmented frames in a small slot table.
// ----------------------------------------------------------------------------
// Channels: frag takes one fragment or sweep item per valid/ready handshake;
// result gives one or more result items per input, the final one marked by
// last; cfg writes register index/data, always ready; the user writes only
// while idle, not enforced by the block. The front checks header fields and
// queues items in a two-entry FIFO, so it keeps taking items while the back
// works or the result waits. An invalid item goes straight to its result.
// A fragment is matched to a slot or given one, checked for a seen piece and
// walked over every range already recorded in its slot (overlap walk over
// the range RAM, up to 64), plus a walk over the 8 slots for the oldest per
// eviction. A sweep gives one result per expired slot, or one result when
// nothing expires. The back takes the next item from the queue only once it
// is idle again, after the last result of the current item is registered.
// Reset clears the slot valid bits, the queue and the output register and
// loads the register defaults; piece rows are cleared on slot allocation.
// When the receiver stalls, the result is held, the back waits and the
// queue fills; frag.ready drops once two items are waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_reassembly_tracker (
  input  wire logic clk,
  input  wire logic rst,
  frt_in_if.sink    frag,
  frt_out_if.source result,
  frt_cfg_if.sink   cfg
);

  frt_pkg::cfg_t  regs;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  frt_pkg::item_t push_item;
  frt_pkg::item_t head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_magic     <= 32'd0;
      regs.expected_version   <= 16'd1;
      regs.header_size        <= 16'd40;
      regs.max_frame_bytes    <= 24'd8388608;
      regs.max_pending_frames <= 3'd4;
      regs.frame_timeout      <= 32'd1000;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        frt_pkg::REG_MAGIC:       regs.expected_magic     <= cfg.data;
        frt_pkg::REG_VERSION:     regs.expected_version   <= cfg.data[15:0];
        frt_pkg::REG_HEADER_SIZE: regs.header_size        <= cfg.data[15:0];
        frt_pkg::REG_MAX_BYTES:   regs.max_frame_bytes    <= cfg.data[23:0];
        frt_pkg::REG_MAX_PENDING: regs.max_pending_frames <= cfg.data[2:0];
        frt_pkg::REG_TIMEOUT:     regs.frame_timeout      <= cfg.data;
        default: ;
      endcase
    end
  end

  frt_front u_front (
    .frag(frag), .cfg(regs), .q_full(q_full), .q_push(q_push), .q_item(push_item)
  );

  frt_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_item(push_item), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .head(head)
  );

  frt_back u_back (
    .clk(clk), .rst(rst), .cfg(regs), .q_valid(q_valid), .q_item(head),
    .q_pop(q_pop), .result(result)
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  a_none_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == 3'(frt_pkg::ST_NONE_EXPIRED)) |-> result.last)
    else $error("nothing-expired result not final");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && ((result.status == 3'(frt_pkg::ST_INVALID))
    || (result.status == 3'(frt_pkg::ST_DUPLICATE))
    || (result.status == 3'(frt_pkg::ST_COMPLETED))) |-> result.last)
    else $error("terminal result not marked last");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == 3'(frt_pkg::ST_INVALID))
    |-> (result.write_offset == 32'd0) && (result.out_stamp == 64'd0))
    else $error("rejected result carries frame data");

endmodule

`default_nettype wire

// ===== sim/tb_fragment_reassembly_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_fragment_reassembly_tracker
// Self-checking bench for the fragment reassembly tracker. Fragment and
// sweep items are queued by a stimulus process and driven with random gaps.
// Each accepted item runs through a slot-table predictor that queues the
// result items it should cause. A monitor checks every result item, in
// order, against that queue. Several register settings are run in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fragment_reassembly_tracker;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        cmd;
    logic [31:0] now;
    logic [15:0] dlen;
    logic [47:0] mv;
    logic [15:0] hlen;
    logic [63:0] fid;
    logic [63:0] stamp;
    logic [31:0] fsize;
    logic [31:0] off;
    logic [15:0] idx;
    logic [15:0] cnt;
    logic [31:0] pay;
  } frag_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  frt_in_if  frag ();
  frt_out_if result ();
  frt_cfg_if cfg ();

  fragment_reassembly_tracker dut (
    .clk    (clk),
    .rst    (rst),
    .frag   (frag),
    .result (result),
    .cfg    (cfg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register mirror
  logic [31:0] cfg_magic    = 32'd0;
  logic [15:0] cfg_version  = 16'd1;
  logic [15:0] cfg_header   = 16'd40;
  logic [23:0] cfg_max_bytes = 24'd8388608;
  logic [2:0]  cfg_pending  = 3'd4;
  logic [31:0] cfg_timeout  = 32'd1000;

  // Slot table mirror
  logic        tab_valid   [frt_pkg::SLOTS];
  logic [63:0] tab_id      [frt_pkg::SLOTS];
  logic [63:0] tab_stamp   [frt_pkg::SLOTS];
  logic [31:0] tab_size    [frt_pkg::SLOTS];
  logic [15:0] tab_total   [frt_pkg::SLOTS];
  logic [31:0] tab_got     [frt_pkg::SLOTS];
  logic [31:0] tab_bytes   [frt_pkg::SLOTS];
  logic [31:0] tab_touched [frt_pkg::SLOTS];
  logic        seen_piece  [frt_pkg::SLOTS*frt_pkg::MAX_PIECES];
  logic [31:0] rng_lo      [frt_pkg::SLOTS*frt_pkg::MAX_PIECES];
  logic [31:0] rng_hi      [frt_pkg::SLOTS*frt_pkg::MAX_PIECES];

  frt_pkg::result_t due_results [$];
  frt_pkg::result_t step_buf [$];
  frag_req_t pend_items [$];
  frag_req_t cur_item;
  bit        frag_busy = 1'b0;
  bit        failed = 1'b0;
  int        cyc = 0;

  function automatic bit pause();
    if ((cyc % 4000) >= 3000) return 1'b0;
    return $urandom_range(0, 99) < 26;
  endfunction

  task automatic add_item(frag_req_t r);
    pend_items = {pend_items, r};
  endtask

  task automatic emit(frt_pkg::status_t st, int s, logic [31:0] wo, logic [63:0] id,
                      logic [63:0] stamp, logic [31:0] size, logic [15:0] cnt);
    frt_pkg::result_t x;
    if (step_buf.size() >= frt_pkg::RESULT_LIMIT) return;
    x.status       = st;
    x.slot         = s[2:0];
    x.write_offset = wo;
    x.frame_id     = id;
    x.stamp        = stamp;
    x.frame_size   = size[23:0];
    x.piece_count  = cnt;
    x.last         = 1'b0;
    step_buf = {step_buf, x};
  endtask

  task automatic emit_slot(frt_pkg::status_t st, int s, logic [31:0] wo);
    emit(st, s, wo, tab_id[s], tab_stamp[s], tab_size[s], tab_total[s]);
  endtask

  function automatic int oldest_slot(logic [31:0] now);
    int best;
    logic [31:0] best_age;
    logic [31:0] age;
    best = -1;
    best_age = 0;
    for (int s = 0; s < frt_pkg::SLOTS; s++) begin
      if (tab_valid[s]) begin
        age = now - tab_touched[s];
        if (best < 0 || age > best_age) begin
          best = s;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  task automatic track_item(frag_req_t r);
    int s, base, got, count, limit, v;
    logic [32:0] fend;
    logic [31:0] room;
    logic [31:0] age;
    bit bad;
    step_buf.delete();
    if (r.cmd == frt_pkg::CMD_SWEEP) begin
      for (s = 0; s < frt_pkg::SLOTS; s++) begin
        age = r.now - tab_touched[s];
        if (tab_valid[s] && age > cfg_timeout) begin
          emit_slot(frt_pkg::ST_EXPIRED, s, 0);
          tab_valid[s] = 1'b0;
        end
      end
      if (step_buf.size() == 0) emit(frt_pkg::ST_NONE_EXPIRED, 0, '0, '0, '0, '0, '0);
    end else if (r.mv[47:16] != cfg_magic || r.mv[15:0] != cfg_version ||
                 r.hlen != cfg_header || r.dlen < cfg_header ||
                 r.fsize == 0 || r.fsize > {8'd0, cfg_max_bytes} ||
                 r.cnt == 0 || r.cnt > frt_pkg::MAX_PIECES || r.idx >= r.cnt ||
                 r.pay == 0 || r.pay != 32'(r.dlen) - 32'(r.hlen) ||
                 r.off > r.fsize || r.pay > r.fsize - r.off) begin
      emit(frt_pkg::ST_INVALID, 0, '0, r.fid, '0, '0, '0);
    end else begin
      fend = {1'b0, r.off} + {1'b0, r.pay};
      for (s = 0; s < frt_pkg::SLOTS; s++)
        if (tab_valid[s] && tab_id[s] == r.fid) break;
      bad = 1'b0;
      if (s == frt_pkg::SLOTS) begin
        for (s = 0; s < frt_pkg::SLOTS; s++)
          if (!tab_valid[s]) break;
        if (s == frt_pkg::SLOTS) begin
          s = oldest_slot(r.now);
          emit_slot(frt_pkg::ST_EVICTED, s, 0);
        end
        tab_valid[s] = 1'b1;
        tab_id[s]    = r.fid;
        tab_stamp[s] = r.stamp;
        tab_size[s]  = r.fsize;
        tab_total[s] = r.cnt;
        tab_got[s]   = 0;
        tab_bytes[s] = 0;
        for (int k = 0; k < frt_pkg::MAX_PIECES; k++)
          seen_piece[s*frt_pkg::MAX_PIECES+k] = 1'b0;
      end else if (tab_stamp[s] != r.stamp || tab_size[s] != r.fsize ||
                   tab_total[s] != r.cnt) begin
        emit(frt_pkg::ST_INVALID, s, '0, r.fid, '0, '0, '0);
        bad = 1'b1;
      end
      if (!bad) begin
        tab_touched[s] = r.now;
        base = s * frt_pkg::MAX_PIECES;
        if (seen_piece[base + r.idx]) begin
          emit(frt_pkg::ST_DUPLICATE, s, '0, r.fid, '0, '0, '0);
        end else begin
          got = (tab_got[s] > frt_pkg::MAX_PIECES) ? frt_pkg::MAX_PIECES : int'(tab_got[s]);
          for (int k = 0; k < got; k++)
            if (r.off < rng_hi[base+k] && fend > {1'b0, rng_lo[base+k]}) bad = 1'b1;
          room = (tab_bytes[s] > tab_size[s]) ? 32'd0 : tab_size[s] - tab_bytes[s];
          if (r.pay > room) bad = 1'b1;
          if (bad) begin
            emit(frt_pkg::ST_INVALID, s, '0, r.fid, '0, '0, '0);
          end else begin
            seen_piece[base + r.idx] = 1'b1;
            if (got < frt_pkg::MAX_PIECES) begin
              rng_lo[base+got] = r.off;
              rng_hi[base+got] = fend[31:0];
            end
            tab_got[s] = got + 1;
            tab_bytes[s] = tab_bytes[s] + r.pay;
            if (tab_got[s] == 32'(tab_total[s]) && tab_bytes[s] == tab_size[s]) begin
              emit_slot(frt_pkg::ST_COMPLETED, s, r.off);
              tab_valid[s] = 1'b0;
            end else begin
              emit_slot(frt_pkg::ST_ACCEPTED, s, r.off);
              limit = (cfg_pending == 0) ? 1 : int'(cfg_pending);
              count = 0;
              for (int k = 0; k < frt_pkg::SLOTS; k++) if (tab_valid[k]) count++;
              while (count > limit) begin
                v = oldest_slot(r.now);
                if (v < 0) break;
                emit_slot(frt_pkg::ST_EVICTED, v, 0);
                tab_valid[v] = 1'b0;
                count--;
              end
            end
          end
        end
      end
    end
    step_buf[step_buf.size()-1].last = 1'b1;
    due_results = {due_results, step_buf};
  endtask

  // Input driver
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst && frag.valid && frag.ready) begin
      track_item(cur_item);
      frag_busy = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst && !frag_busy) begin
      if (pend_items.size() != 0 && !pause()) begin
        cur_item = pend_items[0];
        pend_items.delete(0);
        frag.command           <= cur_item.cmd;
        frag.now_time          <= cur_item.now;
        frag.datagram_length   <= cur_item.dlen;
        frag.magic_and_version <= cur_item.mv;
        frag.header_length     <= cur_item.hlen;
        frag.frame_id          <= cur_item.fid;
        frag.frame_stamp       <= cur_item.stamp;
        frag.frame_size        <= cur_item.fsize;
        frag.byte_offset       <= cur_item.off;
        frag.piece_index       <= cur_item.idx;
        frag.piece_count       <= cur_item.cnt;
        frag.payload_length    <= cur_item.pay;
        frag.valid             <= 1'b1;
        frag_busy = 1'b1;
      end else begin
        frag.valid <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(negedge clk) begin
    if (!rst) result.ready <= !pause();
  end

  always @(posedge clk) begin
    frt_pkg::result_t want;
    if (!rst && result.valid && result.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d slot %0d id %h",
                 $time, result.status, result.slot, result.out_frame_id);
        failed = 1'b1;
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (result.status !== want.status || result.slot !== want.slot ||
            result.write_offset !== want.write_offset ||
            result.out_frame_id !== want.frame_id || result.out_stamp !== want.stamp ||
            result.out_frame_size !== want.frame_size ||
            result.out_piece_count !== want.piece_count || result.last !== want.last) begin
          $display("%0t: mismatch expected st %0d sl %0d wo %h id %h stamp %h size %h cnt %h last %b",
                   $time, want.status, want.slot, want.write_offset, want.frame_id,
                   want.stamp, want.frame_size, want.piece_count, want.last);
          $display("%0t:            actual st %0d sl %0d wo %h id %h stamp %h size %h cnt %h last %b",
                   $time, result.status, result.slot, result.write_offset,
                   result.out_frame_id, result.out_stamp, result.out_frame_size,
                   result.out_piece_count, result.last);
          failed = 1'b1;
        end
      end
    end
  end

  // Stimulus helpers
  logic [31:0] now_t = 32'd0;

  function automatic frag_req_t make_frag(logic [63:0] fid, logic [63:0] stamp,
                                          logic [31:0] size, int cnt,
                                          int idx, logic [31:0] off,
                                          logic [31:0] pay);
    frag_req_t r;
    r.cmd   = frt_pkg::CMD_FRAGMENT;
    r.now   = now_t;
    r.mv    = {cfg_magic, cfg_version};
    r.hlen  = cfg_header;
    r.dlen  = cfg_header + pay[15:0];
    r.fid   = fid;
    r.stamp = stamp;
    r.fsize = size;
    r.cnt   = 16'(cnt);
    r.idx   = 16'(idx);
    r.off   = off;
    r.pay   = pay;
    return r;
  endfunction

  function automatic frag_req_t make_sweep();
    frag_req_t r;
    r = make_frag({$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
    r.cmd = frt_pkg::CMD_SWEEP;
    return r;
  endfunction

  task automatic write_reg(frt_pkg::reg_index_t idx, logic [31:0] data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      frt_pkg::REG_MAGIC:       cfg_magic     = data;
      frt_pkg::REG_VERSION:     cfg_version   = data[15:0];
      frt_pkg::REG_HEADER_SIZE: cfg_header    = data[15:0];
      frt_pkg::REG_MAX_BYTES:   cfg_max_bytes = data[23:0];
      frt_pkg::REG_MAX_PENDING: cfg_pending   = data[2:0];
      frt_pkg::REG_TIMEOUT:     cfg_timeout   = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] magic, logic [15:0] ver, logic [15:0] hdr,
                          logic [23:0] maxb, logic [2:0] pend, logic [31:0] tmo);
    write_reg(frt_pkg::REG_MAGIC, magic);
    write_reg(frt_pkg::REG_VERSION, {16'd0, ver});
    write_reg(frt_pkg::REG_HEADER_SIZE, {16'd0, hdr});
    write_reg(frt_pkg::REG_MAX_BYTES, {8'd0, maxb});
    write_reg(frt_pkg::REG_MAX_PENDING, {29'd0, pend});
    write_reg(frt_pkg::REG_TIMEOUT, tmo);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pend_items.size() != 0 || frag_busy || due_results.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Frames in flight for the random part
  localparam int PLANS = 6;
  bit          plan_live  [PLANS];
  logic [63:0] plan_fid   [PLANS];
  logic [63:0] plan_stamp [PLANS];
  int          plan_cnt   [PLANS];
  int          plan_chunk [PLANS];
  int          plan_next  [PLANS];
  int          plan_order [PLANS][frt_pkg::MAX_PIECES];

  task automatic new_plan(int p);
    int cmax, j, t;
    plan_cnt[p] = ($urandom_range(0, 9) == 0) ? frt_pkg::MAX_PIECES : $urandom_range(1, 6);
    if (cfg_max_bytes < plan_cnt[p]) plan_cnt[p] = 1;
    cmax = cfg_max_bytes / plan_cnt[p];
    if (cmax > 60) cmax = 60;
    plan_chunk[p] = $urandom_range(1, cmax);
    plan_fid[p]   = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 15))
                                                : {$urandom, $urandom};
    plan_stamp[p] = {$urandom, $urandom};
    plan_next[p]  = 0;
    for (int k = 0; k < plan_cnt[p]; k++) plan_order[p][k] = k;
    for (int k = plan_cnt[p] - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = plan_order[p][k];
      plan_order[p][k] = plan_order[p][j];
      plan_order[p][j] = t;
    end
    plan_live[p] = 1'b1;
  endtask

  task automatic random_items(int total);
    int p, roll, idx, size, off;
    frag_req_t r;
    for (int p0 = 0; p0 < PLANS; p0++) plan_live[p0] = 1'b0;
    for (int n = 0; n < total; n++) begin
      p = $urandom_range(0, PLANS - 1);
      if (!plan_live[p]) new_plan(p);
      size = plan_cnt[p] * plan_chunk[p];
      roll = $urandom_range(0, 99);
      if (roll < 62) begin
        idx = plan_order[p][plan_next[p]];
        r = make_frag(plan_fid[p], plan_stamp[p], size, plan_cnt[p], idx,
                      idx * plan_chunk[p], plan_chunk[p]);
        plan_next[p]++;
        if (plan_next[p] == plan_cnt[p]) plan_live[p] = 1'b0;
      end else if (roll < 70) begin
        idx = $urandom_range(0, plan_cnt[p] - 1);
        r = make_frag(plan_fid[p], plan_stamp[p], size, plan_cnt[p], idx,
                      idx * plan_chunk[p], plan_chunk[p]);
      end else if (roll < 76) begin
        off = $urandom_range(0, size - 1);
        r = make_frag(plan_fid[p], plan_stamp[p], size, plan_cnt[p],
                      $urandom_range(0, plan_cnt[p] - 1), off, $urandom_range(1, size - off));
      end else if (roll < 81) begin
        r = make_frag(plan_fid[p], plan_stamp[p] + 1, size, plan_cnt[p], 0, 0,
                      plan_chunk[p]);
      end else if (roll < 89) begin
        r = make_sweep();
        r.cmd = frt_pkg::CMD_FRAGMENT;
        r.dlen = 16'($urandom);
        r.mv = 48'({$urandom, $urandom});
        r.hlen = 16'($urandom);
      end else begin
        r = make_sweep();
      end
      r.now = now_t;
      add_item(r);
      if ($urandom_range(0, 99) < 4) now_t = now_t + cfg_timeout + $urandom_range(0, 3);
      else if ($urandom_range(0, 99) < 2) now_t = $urandom;
      else now_t = now_t + $urandom_range(0, 40);
    end
  endtask

  initial begin
    frag_req_t b, r;
    frag.valid = 1'b0;
    frag.command = frt_pkg::CMD_FRAGMENT;
    frag.now_time = '0;
    frag.datagram_length = '0;
    frag.magic_and_version = '0;
    frag.header_length = '0;
    frag.frame_id = '0;
    frag.frame_stamp = '0;
    frag.frame_size = '0;
    frag.byte_offset = '0;
    frag.piece_index = '0;
    frag.piece_count = '0;
    frag.payload_length = '0;
    result.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = frt_pkg::REG_MAGIC;
    cfg.data = '0;
    for (int s = 0; s < frt_pkg::SLOTS; s++) tab_valid[s] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part on the reset settings
    add_item(make_sweep());
    add_item(make_frag('1, '1, 100, 1, 0, 0, 100));
    add_item(make_frag(64'd5, 64'd7, 20, 2, 0, 0, 10));
    add_item(make_frag(64'd5, 64'd7, 20, 2, 0, 0, 10));
    add_item(make_frag(64'd5, 64'd8, 20, 2, 1, 10, 10));
    add_item(make_frag(64'd5, 64'd7, 20, 2, 1, 5, 10));
    add_item(make_frag(64'd5, 64'd7, 20, 2, 1, 10, 10));
    b = make_frag(64'd9, 64'd0, 10, 1, 0, 0, 10);
    r = b; r.mv[47:16] = 32'd1;               add_item(r);
    r = b; r.mv[15:0] = 16'd0;                add_item(r);
    r = b; r.hlen = 16'd41;                   add_item(r);
    r = b; r.dlen = 16'd39;                   add_item(r);
    r = b; r.fsize = 32'd0;                   add_item(r);
    r = b; r.fsize = 32'd8388609;             add_item(r);
    r = b; r.cnt = 16'd0;                     add_item(r);
    r = b; r.cnt = 16'(frt_pkg::MAX_PIECES + 1); add_item(r);
    r = b; r.idx = 16'd1;                     add_item(r);
    r = b; r.pay = 32'd0; r.dlen = 16'd40;    add_item(r);
    r = b; r.pay = 32'd11;                    add_item(r);
    r = b; r.off = 32'd11;                    add_item(r);
    r = b; r.off = 32'd5;                     add_item(r);
    // One frame over the pending limit forces an eviction
    for (int k = 0; k < 5; k++) begin
      now_t = now_t + 10;
      add_item(make_frag(64'(100 + k), 64'(k), 20, 2, 0, 0, 10));
    end
    now_t = now_t + 5000;
    add_item(make_sweep());
    pend_items[$].now = now_t;
    drain();

    set_regs(32'hA5C3_0F1E, 16'd2, 16'd16, 24'd4096, 3'd3, 32'd300);
    random_items(90);
    drain();

    set_regs(32'hFFFF_FFFF, 16'hFFFF, 16'd1, 24'hFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    random_items(80);
    drain();

    set_regs(32'd0, 16'd0, 16'd200, 24'd1, 3'd1, 32'd0);
    random_items(40);
    drain();

    set_regs(32'h1234_5678, 16'h8000, 16'd40, 24'd600, 3'd2, 32'd60);
    random_items(40);
    drain();

    if (!failed) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/frt_pkg.sv
src/frt_if.sv
src/frt_ram.sv
src/frt_front.sv
src/frt_queue.sv
src/frt_back.sv
src/fragment_reassembly_tracker.sv
sim/tb_fragment_reassembly_tracker.sv
